/* rtl/ustcd_pkg.sv */
`default_nettype none

package ustcd_pkg;

   // Pipeline depth: time split, calendar date, output register
   localparam int SPLIT_STAGES = 5;
   localparam int DATE_STAGES  = 5;
   localparam int NUM_STAGES   = SPLIT_STAGES + DATE_STAGES + 1;

   localparam logic [3:0] ZONE_RESET = 4'd8;

   localparam int SEC_PER_MIN   = 60;
   localparam int MIN_PER_HOUR  = 60;
   localparam int HOUR_PER_DAY  = 24;
   localparam int SEC_PER_HOUR  = 3600;
   localparam int SEC_PER_DAY   = 86400;
   localparam int MONTHS_PER_YEAR = 12;

   // Reciprocals for truncating division by constants: q = (x * RECIP) >> SHIFT,
   // exact for x below 2**(SHIFT - ceil(log2(divisor))).
   localparam int          SECS_SHIFT = 38;
   localparam logic [32:0] SECS_RECIP =
      33'(((64'd1 << SECS_SHIFT) + 64'd59) / 64'd60);
   localparam int          MINS_SHIFT = 33;
   localparam logic [27:0] MINS_RECIP =
      28'(((64'd1 << MINS_SHIFT) + 64'd59) / 64'd60);
   localparam int          HOURS_SHIFT = 26;
   localparam logic [21:0] HOURS_RECIP =
      22'(((64'd1 << HOURS_SHIFT) + 64'd23) / 64'd24);
   localparam int          QUAD_SHIFT = 29;
   localparam logic [18:0] QUAD_RECIP =
      19'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);
   localparam int          MON_SHIFT = 20;
   localparam logic [12:0] MON_RECIP =
      13'(((64'd1 << MON_SHIFT) + 64'd152) / 64'd153);

   // Julian day number constants
   localparam logic [21:0] JDN_SHIFT     = 22'd2472632;
   localparam int          ERA_DAYS      = 146097;
   localparam int          QUAD_DAYS     = 1461;
   localparam int          YEAR_BASE     = 6700;
   localparam int          CENTURY_YEARS = 100;
   localparam int          CENTURY_FIRST = YEAR_BASE / CENTURY_YEARS;
   localparam logic [21:0] CENT_START0   = 22'(CENTURY_FIRST * ERA_DAYS / 4);
   localparam logic [21:0] CENT_START1   = 22'((CENTURY_FIRST + 1) * ERA_DAYS / 4);
   localparam logic [21:0] CENT_START2   = 22'((CENTURY_FIRST + 2) * ERA_DAYS / 4);
   localparam logic [3:0]  MONTH_WRAP    = 4'd10;

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hour;
   } tod_type;

   typedef struct packed {
      tod_type     tod;
      logic [21:0] day_num;
   } split_type;

   typedef struct packed {
      tod_type     tod;
      logic [7:0]  year;
      logic [3:0]  mon;
      logic [4:0]  day_m1;
      logic [16:0] day_sec;
   } date_type;

   // First day of shifted month m (March is zero): (153 * m + 2) / 5
   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/ustcd_time_split.sv */
`default_nettype none

module ustcd_time_split
   import ustcd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [SPLIT_STAGES-1:0] advance,
   input  wire logic [31:0]             unix_seconds,
   input  wire logic [3:0]              zone_offset,
   output split_type                    result
);

   logic [31:0] t1_ff;
   logic [26:0] mins1_ff, mins1_in;
   logic [64:0] mins_prod;

   logic [26:0] mins2_ff;
   logic [5:0]  sec2_ff, sec2_in;
   logic [20:0] hrs2_ff, hrs2_in;
   logic [31:0] sec_full;
   logic [54:0] hrs_prod;

   logic [5:0]  sec3_ff, min3_ff, min3_in;
   logic [20:0] hours3_ff, hours3_in;
   logic [26:0] min_full;

   logic [5:0]  sec4_ff, min4_ff;
   logic [20:0] hours4_ff;
   logic [15:0] days4_ff, days4_in;
   logic [42:0] days_prod;

   logic [20:0] hour_full;
   split_type   result_ff, result_in;

   always_comb begin
      mins_prod = 65'(unix_seconds) * 65'(SECS_RECIP);
      mins1_in  = mins_prod[SECS_SHIFT +: 27];

      sec_full  = t1_ff - 32'(mins1_ff) * 32'(SEC_PER_MIN);
      sec2_in   = sec_full[5:0];
      hrs_prod  = 55'(mins1_ff) * 55'(MINS_RECIP);
      hrs2_in   = hrs_prod[MINS_SHIFT +: 21];

      min_full  = mins2_ff - 27'(hrs2_ff) * 27'(MIN_PER_HOUR);
      min3_in   = min_full[5:0];
      hours3_in = hrs2_ff + 21'(zone_offset);

      days_prod = 43'(hours3_ff) * 43'(HOURS_RECIP);
      days4_in  = days_prod[HOURS_SHIFT +: 16];

      hour_full = hours4_ff - 21'(days4_ff) * 21'(HOUR_PER_DAY);
      result_in.tod.sec  = sec4_ff;
      result_in.tod.min  = min4_ff;
      result_in.tod.hour = hour_full[4:0];
      result_in.day_num  = 22'(days4_ff) + JDN_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         t1_ff    <= unix_seconds;
         mins1_ff <= mins1_in;
      end
      if (advance[1]) begin
         mins2_ff <= mins1_ff;
         sec2_ff  <= sec2_in;
         hrs2_ff  <= hrs2_in;
      end
      if (advance[2]) begin
         sec3_ff   <= sec2_ff;
         min3_ff   <= min3_in;
         hours3_ff <= hours3_in;
      end
      if (advance[3]) begin
         sec4_ff   <= sec3_ff;
         min4_ff   <= min3_ff;
         hours4_ff <= hours3_ff;
         days4_ff  <= days4_in;
      end
      if (advance[4]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* rtl/ustcd_jdn_date.sv */
`default_nettype none

module ustcd_jdn_date
   import ustcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [DATE_STAGES-1:0] advance,
   input  wire split_type              in_item,
   output date_type                    result
);

   tod_type     tod6_ff, tod7_ff, tod8_ff, tod9_ff;
   logic [1:0]  bi6_ff, bi6_in, bi7_ff, bi8_ff, bi9_ff;
   logic [15:0] c6_ff, c6_in, c7_ff;
   logic [21:0] cent_start, c_full;
   logic [6:0]  d7_ff, d7_in, d8_ff, d9_ff;
   logic [36:0] quad_prod;
   logic [8:0]  e8_ff, e8_in, e9_ff;
   logic [17:0] quad_days, e_full;
   logic [11:0] mon_num;
   logic [24:0] mon_prod;
   logic [3:0]  m9_ff, m9_in;
   logic        wrap;
   logic [8:0]  year_full, day_m1_full;
   date_type    result_ff, result_in;

   always_comb begin
      // Pick the century: at most two steps above the first one in range
      if (in_item.day_num >= CENT_START2) begin
         bi6_in     = 2'd2;
         cent_start = CENT_START2;
      end else if (in_item.day_num >= CENT_START1) begin
         bi6_in     = 2'd1;
         cent_start = CENT_START1;
      end else begin
         bi6_in     = 2'd0;
         cent_start = CENT_START0;
      end
      c_full = in_item.day_num - cent_start;
      c6_in  = c_full[15:0];

      quad_prod = 37'({c6_ff, 2'b11}) * 37'(QUAD_RECIP);
      d7_in     = quad_prod[QUAD_SHIFT +: 7];

      quad_days = 18'(d7_ff) * 18'(QUAD_DAYS);
      e_full    = 18'(c7_ff) - (quad_days >> 2);
      e8_in     = e_full[8:0];

      mon_num  = 12'(e8_ff) * 12'd5 + 12'd2;
      mon_prod = 25'(mon_num) * 25'(MON_RECIP);
      m9_in    = mon_prod[MON_SHIFT +: 4];

      wrap        = (m9_ff >= MONTH_WRAP);
      year_full   = 9'(bi9_ff) * 9'(CENTURY_YEARS) + 9'(d9_ff) + 9'(wrap);
      day_m1_full = e9_ff - month_start(m9_ff);
      result_in.tod     = tod9_ff;
      result_in.year    = year_full[7:0];
      result_in.mon     = wrap ? (m9_ff - MONTH_WRAP) : (m9_ff + 4'd2);
      result_in.day_m1  = day_m1_full[4:0];
      result_in.day_sec = 17'(tod9_ff.hour) * 17'(SEC_PER_HOUR)
                        + 17'(tod9_ff.min) * 17'(SEC_PER_MIN)
                        + 17'(tod9_ff.sec);
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         tod6_ff <= in_item.tod;
         bi6_ff  <= bi6_in;
         c6_ff   <= c6_in;
      end
      if (advance[1]) begin
         tod7_ff <= tod6_ff;
         bi7_ff  <= bi6_ff;
         c7_ff   <= c6_ff;
         d7_ff   <= d7_in;
      end
      if (advance[2]) begin
         tod8_ff <= tod7_ff;
         bi8_ff  <= bi7_ff;
         d8_ff   <= d7_ff;
         e8_ff   <= e8_in;
      end
      if (advance[3]) begin
         tod9_ff <= tod8_ff;
         bi9_ff  <= bi8_ff;
         d9_ff   <= d8_ff;
         e9_ff   <= e8_ff;
         m9_ff   <= m9_in;
      end
      if (advance[4]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* rtl/unix_seconds_to_civil_date_core.sv */
// Unix seconds to local civil date and time.
//
// Request channel: req_valid / req_stall carry req_unix_seconds. An item is
// taken on a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall carry the broken-down local time,
// the seconds into the day and the seconds into the month; one response
// per request, in order.
// Config channel: csr_valid / csr_ready write csr_zone_offset_hours, the
// whole hours added to UTC. csr_ready is always high. Write only while idle.
//
// Register stages: 11, five for the time split, five for the date and one
// output stage. Throughput: one item per cycle while req_stall is low.
// Reset (synchronous, active high) empties the pipeline and sets the offset
// to 8 hours. While rsp_stall holds a response, younger items keep moving
// into empty stages; req_stall rises only once every stage is occupied.
`default_nettype none

module unix_seconds_to_civil_date_core
   import ustcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_unix_seconds,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_years_since_1900,
   output logic [3:0]       rsp_month_index,
   output logic [4:0]       rsp_day_of_month,
   output logic [4:0]       rsp_hour_of_day,
   output logic [5:0]       rsp_minute_of_hour,
   output logic [5:0]       rsp_second_of_minute,
   output logic [16:0]      rsp_seconds_into_day,
   output logic [21:0]      rsp_seconds_into_month,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_zone_offset_hours
);

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] advance;
   logic [3:0]            zone_ff;
   split_type             split_item;
   date_type              date_item;

   logic [7:0]  year_ff;
   logic [3:0]  mon_ff;
   logic [4:0]  mday_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  min_ff, sec_ff;
   logic [16:0] daysec_ff;
   logic [21:0] monsec_ff, monsec_in;

   // A stage may load when rsp_stall is low or when it or any stage after it holds a bubble
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         advance[i] = !rsp_stall
                    || !(&(valid_ff | NUM_STAGES'((64'd1 << i) - 64'd1)));
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (i == 0) begin
            valid_in[i] = advance[i] ? req_valid : valid_ff[i];
         end else begin
            valid_in[i] = advance[i] ? valid_ff[i-1] : valid_ff[i];
         end
      end
      monsec_in = 22'(date_item.day_m1) * 22'(SEC_PER_DAY) + 22'(date_item.day_sec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         zone_ff  <= ZONE_RESET;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid) begin
            zone_ff <= csr_zone_offset_hours;
         end
      end
   end

   ustcd_time_split u_split (
      .clock        (clock),
      .advance      (advance[SPLIT_STAGES-1:0]),
      .unix_seconds (req_unix_seconds),
      .zone_offset  (zone_ff),
      .result       (split_item)
   );

   ustcd_jdn_date u_date (
      .clock   (clock),
      .advance (advance[SPLIT_STAGES +: DATE_STAGES]),
      .in_item (split_item),
      .result  (date_item)
   );

   always_ff @(posedge clock) begin
      if (advance[NUM_STAGES-1]) begin
         year_ff   <= date_item.year;
         mon_ff    <= date_item.mon;
         mday_ff   <= date_item.day_m1 + 5'd1;
         hour_ff   <= date_item.tod.hour;
         min_ff    <= date_item.tod.min;
         sec_ff    <= date_item.tod.sec;
         daysec_ff <= date_item.day_sec;
         monsec_ff <= monsec_in;
      end
   end

   assign req_stall              = !advance[0];
   assign csr_ready              = 1'b1;
   assign rsp_valid              = valid_ff[NUM_STAGES-1];
   assign rsp_years_since_1900   = year_ff;
   assign rsp_month_index        = mon_ff;
   assign rsp_day_of_month       = mday_ff;
   assign rsp_hour_of_day        = hour_ff;
   assign rsp_minute_of_hour     = min_ff;
   assign rsp_second_of_minute   = sec_ff;
   assign rsp_seconds_into_day   = daysec_ff;
   assign rsp_seconds_into_month = monsec_ff;

`ifndef NO_ASSERTIONS
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_index < 4'(MONTHS_PER_YEAR)) && (rsp_day_of_month != 5'd0))
      else $error("month or day out of range");

   a_day_seconds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seconds_into_day == 17'(rsp_hour_of_day) * 17'(SEC_PER_HOUR)
                    + 17'(rsp_minute_of_hour) * 17'(SEC_PER_MIN)
                    + 17'(rsp_second_of_minute))
      else $error("seconds into day disagree with hour, minute and second");

   a_month_seconds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seconds_into_month
                    == 22'(rsp_day_of_month - 5'd1) * 22'(SEC_PER_DAY)
                    + 22'(rsp_seconds_into_day))
      else $error("seconds into month disagree with day of month");
`endif

endmodule

`default_nettype wire

/* tb/civil_date_checker.sv */
`timescale 1ns / 1ps

module civil_date_checker
   import ustcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [31:0] req_unix_seconds,

   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_years_since_1900,
   input  wire logic [3:0]  rsp_month_index,
   input  wire logic [4:0]  rsp_day_of_month,
   input  wire logic [4:0]  rsp_hour_of_day,
   input  wire logic [5:0]  rsp_minute_of_hour,
   input  wire logic [5:0]  rsp_second_of_minute,
   input  wire logic [16:0] rsp_seconds_into_day,
   input  wire logic [21:0] rsp_seconds_into_month,

   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [3:0]  csr_zone_offset_hours,

   output int               mismatch_count,
   output int               outstanding
);

   typedef struct packed {
      logic [7:0]  years;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [16:0] day_secs;
      logic [21:0] month_secs;
   } civil_time_type;

   civil_time_type expected_dates[$];
   logic [3:0]     zone_hours;

   function automatic civil_time_type civil_from_unix(input logic [31:0] secs,
                                                      input logic [3:0]  zone);
      bit [63:0]      total_min, total_hr, days;
      bit [63:0]      sec, minute, hour;
      bit [63:0]      jdn, century, day_in_century, year_in_century, day_in_year;
      bit [63:0]      shifted_month, mday, wrap, month, year, day_secs, month_secs;
      civil_time_type r;
      sec             = 64'(secs) % 64'd60;
      total_min       = 64'(secs) / 64'd60;
      minute          = total_min % 64'd60;
      total_hr        = total_min / 64'd60 + 64'(zone);
      hour            = total_hr % 64'd24;
      days            = total_hr / 64'd24;
      jdn             = days + 64'd2472632;
      century         = (jdn * 64'd4 + 64'd3) / 64'd146097;
      day_in_century  = jdn - (century * 64'd146097) / 64'd4;
      year_in_century = (day_in_century * 64'd4 + 64'd3) / 64'd1461;
      day_in_year     = day_in_century - (year_in_century * 64'd1461) / 64'd4;
      shifted_month   = (64'd5 * day_in_year + 64'd2) / 64'd153;
      mday            = day_in_year - (64'd153 * shifted_month + 64'd2) / 64'd5 + 64'd1;
      // March-based month index wraps into the next year for Jan and Feb
      wrap            = shifted_month / 64'd10;
      month           = shifted_month + 64'd2 - 64'd12 * wrap;
      year            = century * 64'd100 + year_in_century + wrap - 64'd6700;
      day_secs        = hour * 64'd3600 + minute * 64'd60 + sec;
      month_secs      = (mday - 64'd1) * 64'd86400 + day_secs;
      r.years      = year[7:0];
      r.month      = month[3:0];
      r.mday       = mday[4:0];
      r.hour       = hour[4:0];
      r.minute     = minute[5:0];
      r.second     = sec[5:0];
      r.day_secs   = day_secs[16:0];
      r.month_secs = month_secs[21:0];
      return r;
   endfunction

   function automatic int field_differs(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      civil_time_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         zone_hours <= ZONE_RESET;
         expected_dates.delete();
         outstanding    <= 0;
         mismatch_count <= 0;
      end else begin
         // predict with the offset in force before this edge's write
         if (req_valid && !req_stall)
            expected_dates.push_back(civil_from_unix(req_unix_seconds, zone_hours));
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               $error("response item with no conversion outstanding");
               errs++;
            end else begin
               want = expected_dates.pop_front();
               errs += field_differs("years_since_1900", 32'(want.years),
                                     32'(rsp_years_since_1900));
               errs += field_differs("month_index", 32'(want.month), 32'(rsp_month_index));
               errs += field_differs("day_of_month", 32'(want.mday), 32'(rsp_day_of_month));
               errs += field_differs("hour_of_day", 32'(want.hour), 32'(rsp_hour_of_day));
               errs += field_differs("minute_of_hour", 32'(want.minute),
                                     32'(rsp_minute_of_hour));
               errs += field_differs("second_of_minute", 32'(want.second),
                                     32'(rsp_second_of_minute));
               errs += field_differs("seconds_into_day", 32'(want.day_secs),
                                     32'(rsp_seconds_into_day));
               errs += field_differs("seconds_into_month", 32'(want.month_secs),
                                     32'(rsp_seconds_into_month));
            end
         end
         if (csr_valid && csr_ready)
            zone_hours <= csr_zone_offset_hours;
         outstanding    <= expected_dates.size();
         mismatch_count <= mismatch_count + errs;
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ustcd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_unix_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_years_since_1900;
   logic [3:0]  rsp_month_index;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_second_of_minute;
   logic [16:0] rsp_seconds_into_day;
   logic [21:0] rsp_seconds_into_month;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_zone_offset_hours;

   int          mismatch_count;
   int          outstanding;

   bit          calm;
   bit          long_hold_go;
   int          hold_left;
   int          items_sent;
   int          zones_written;

   unix_seconds_to_civil_date_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_unix_seconds       (req_unix_seconds),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_years_since_1900   (rsp_years_since_1900),
      .rsp_month_index        (rsp_month_index),
      .rsp_day_of_month       (rsp_day_of_month),
      .rsp_hour_of_day        (rsp_hour_of_day),
      .rsp_minute_of_hour     (rsp_minute_of_hour),
      .rsp_second_of_minute   (rsp_second_of_minute),
      .rsp_seconds_into_day   (rsp_seconds_into_day),
      .rsp_seconds_into_month (rsp_seconds_into_month),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_zone_offset_hours  (csr_zone_offset_hours)
   );

   civil_date_checker watcher (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_unix_seconds       (req_unix_seconds),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_years_since_1900   (rsp_years_since_1900),
      .rsp_month_index        (rsp_month_index),
      .rsp_day_of_month       (rsp_day_of_month),
      .rsp_hour_of_day        (rsp_hour_of_day),
      .rsp_minute_of_hour     (rsp_minute_of_hour),
      .rsp_second_of_minute   (rsp_second_of_minute),
      .rsp_seconds_into_day   (rsp_seconds_into_day),
      .rsp_seconds_into_month (rsp_seconds_into_month),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_zone_offset_hours  (csr_zone_offset_hours),
      .mismatch_count         (mismatch_count),
      .outstanding            (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off to back up the pipeline
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            hold_left    = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
         end
      end
   end

   task automatic send_item(input logic [31:0] value);
      if (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(0, 99) < 34);
      end
      req_valid        <= 1'b1;
      req_unix_seconds <= value;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain_conversions();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_zone(input logic [3:0] hours);
      csr_valid             <= 1'b1;
      csr_zone_offset_hours <= hours;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      zones_written++;
   endtask

   function automatic logic [31:0] random_seconds();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return $urandom();
      // day boundaries: last second of a day or first of the next
      if (pick < 80)
         return 32'($urandom_range(1, 49710)) * 32'd86400 - 32'($urandom_range(0, 1));
      if (pick < 90)
         return 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
      return 32'($urandom_range(0, 200000));
   endfunction

   logic [31:0] corner_seconds[22] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd68169599, 32'd68169600, 32'd951782400, 32'd951868800,
      32'd946684799, 32'd946684800, 32'h7FFF_FFFF, 32'h8000_0000,
      32'd4107542399, 32'd4107542400, 32'd4294944000, 32'hFFFF_FFFE,
      32'hFFFF_FFFF, 32'hAAAA_AAAA
   };

   logic [3:0] zone_plan[7];

   initial begin
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_unix_seconds      = '0;
      csr_valid             = 1'b0;
      csr_zone_offset_hours = '0;
      calm                  = 1'b0;
      long_hold_go          = 1'b0;
      items_sent            = 0;
      zones_written         = 0;
      zone_plan = '{4'd0, 4'd15, 4'd14, 4'd0, 4'd1, 4'd0, 4'd8};
      zone_plan[3] = 4'($urandom_range(2, 13));
      zone_plan[5] = 4'($urandom());

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corners at the reset offset
      foreach (corner_seconds[i])
         send_item(corner_seconds[i]);

      for (int phase = 0; phase < 7; phase++) begin
         drain_conversions();
         write_zone(zone_plan[phase]);
         calm = (phase == 3);
         if (phase == 2)
            long_hold_go = 1'b1;
         for (int n = 0; n < 100; n++) begin
            // pause the sender until every conversion has come back
            if (phase == 4 && n == 50)
               drain_conversions();
            send_item(random_seconds());
         end
      end
      calm = 1'b0;

      drain_conversions();
      repeat (2 * NUM_STAGES) @(posedge clock);

      $display("Checked %0d conversions over %0d offset writes (0, 14 and 15 included),",
               items_sent, zones_written);
      $display("with a long response hold-off, a drained pause and a no-idle stretch.");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
